[hdl/ucrh_pkg.sv]
// ----------------------------------------------------------------------------
// ucrh_pkg
// Shared types and constants for the control request handler.
// ----------------------------------------------------------------------------
package ucrh_pkg;

    localparam int MEM_DEPTH = 4096;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);

    localparam logic [1:0] HS_STALL  = 2'd0;
    localparam logic [1:0] HS_STATUS = 2'd1;
    localparam logic [1:0] HS_DATA   = 2'd2;

    localparam logic [2:0] SRC_NONE   = 3'd0;
    localparam logic [2:0] SRC_INLINE = 3'd1;
    localparam logic [2:0] SRC_DEVICE = 3'd2;
    localparam logic [2:0] SRC_CONFIG = 3'd3;
    localparam logic [2:0] SRC_REPORT = 3'd4;

    localparam logic [7:0] CMD_BURST_HI = 8'h10;
    localparam logic [7:0] CMD_END      = 8'hed;
    localparam logic [7:0] CMD_READ     = 8'hb5;
    localparam logic [7:0] CMD_WRITE1   = 8'hb6;

    // classified work handed from front to back
    typedef enum logic [2:0] {
        OP_PLAIN,
        OP_SET_ADDR,
        OP_GET_REPORT,
        OP_GET_IDLE,
        OP_REPORT_CMD,
        OP_SET_IDLE
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [1:0]  hs;
        logic [2:0]  src;
        logic [3:0]  off;
        logic [5:0]  len;
        logic [63:0] inl;
        logic [7:0]  vlo;
        logic [7:0]  vhi;
        logic [7:0]  len_in;
        logic [63:0] payload;
    } job_t;

    typedef struct packed {
        logic [1:0]  hs;
        logic [2:0]  src;
        logic [3:0]  off;
        logic [5:0]  len;
        logic [63:0] inl;
        logic [6:0]  addr;
        logic        done;
    } result_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MEM,
        ST_WAIT,
        ST_OUT
    } exec_state_t;

endpackage

[hdl/ucrh_front.sv]
// ----------------------------------------------------------------------------
// ucrh_front
// Accepts setup words and decodes them into jobs for the back end.
// ----------------------------------------------------------------------------
module ucrh_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [103:0]     in_data,
    output logic             job_valid,
    input  logic             job_ready,
    output ucrh_pkg::job_t   job
);

    logic               full_reg;
    ucrh_pkg::job_t     job_reg;
    ucrh_pkg::job_t     job_next;
    logic [7:0] rtype, code, vlo, vhi, len;

    assign rtype = in_data[7:0];
    assign code  = in_data[15:8];
    assign vlo   = in_data[23:16];
    assign vhi   = in_data[31:24];
    assign len   = in_data[39:32];

    assign in_ready  = !full_reg || job_ready;
    assign job_valid = full_reg;
    assign job       = job_reg;

    always_comb
    begin
        job_next = '0;
        job_next.op      = ucrh_pkg::OP_PLAIN;
        job_next.hs      = ucrh_pkg::HS_DATA;
        job_next.src     = ucrh_pkg::SRC_NONE;
        job_next.vlo     = vlo;
        job_next.vhi     = vhi;
        job_next.len_in  = len;
        job_next.payload = in_data[103:40];
        if (rtype[6:5] == 2'b00)
        begin
            case (code)
                8'd0:
                begin
                    job_next.src = ucrh_pkg::SRC_INLINE;
                    job_next.len = 6'd2;
                end
                8'd5:
                begin
                    job_next.op = ucrh_pkg::OP_SET_ADDR;
                    job_next.hs = ucrh_pkg::HS_STATUS;
                end
                8'd6:
                begin
                    if (rtype == 8'h80)
                    begin
                        if (vhi == 8'd1)
                        begin
                            job_next.src = ucrh_pkg::SRC_DEVICE;
                            job_next.len = (len > 8'd63) ? 6'd63 : len[5:0];
                        end
                        else if (vhi == 8'd2)
                        begin
                            job_next.src = ucrh_pkg::SRC_CONFIG;
                            job_next.len = (len > 8'd27) ? 6'd27 : len[5:0];
                        end
                        else
                            job_next.hs = ucrh_pkg::HS_STALL;
                    end
                    else if (rtype == 8'h81)
                    begin
                        if (vhi == 8'h21)
                        begin
                            job_next.src = ucrh_pkg::SRC_CONFIG;
                            job_next.off = 4'd9;
                            job_next.len = 6'd9;
                        end
                        else if (vhi == 8'h22)
                        begin
                            job_next.src = ucrh_pkg::SRC_REPORT;
                            job_next.len = 6'd23;
                        end
                    end
                    else
                        job_next.hs = ucrh_pkg::HS_STALL;
                end
                8'd8:
                begin
                    job_next.src = ucrh_pkg::SRC_INLINE;
                    job_next.len = 6'd1;
                    job_next.inl = 64'd1;
                end
                8'd9:    job_next.hs = ucrh_pkg::HS_STATUS;
                default: job_next.hs = ucrh_pkg::HS_STALL;
            endcase
        end
        else if (rtype[5])
        begin
            case (code)
                8'd1:
                begin
                    job_next.op  = ucrh_pkg::OP_GET_REPORT;
                    job_next.src = ucrh_pkg::SRC_INLINE;
                    job_next.len = 6'd8;
                end
                8'd2:
                begin
                    job_next.op  = ucrh_pkg::OP_GET_IDLE;
                    job_next.src = ucrh_pkg::SRC_INLINE;
                    job_next.len = 6'd1;
                end
                8'd9:
                begin
                    job_next.op = ucrh_pkg::OP_REPORT_CMD;
                    job_next.hs = ucrh_pkg::HS_STATUS;
                end
                8'd10:
                begin
                    job_next.op = ucrh_pkg::OP_SET_IDLE;
                    job_next.hs = ucrh_pkg::HS_STATUS;
                end
                default: job_next.hs = ucrh_pkg::HS_STALL;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            full_reg <= 1'b0;
        else if (in_ready)
            full_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            job_reg <= job_next;
    end

endmodule

[hdl/ucrh_back.sv]
// ----------------------------------------------------------------------------
// ucrh_back
// Executes jobs: device state, report buffer and byte memory commands.
// ----------------------------------------------------------------------------
module ucrh_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               job_valid,
    output logic               job_ready,
    input  ucrh_pkg::job_t     job,
    output logic               res_valid,
    input  logic               res_ready,
    output ucrh_pkg::result_t  res
);

    localparam int AW = ucrh_pkg::MEM_AW;

    ucrh_pkg::exec_state_t state_reg, state_next;
    logic [7:0]   mem [ucrh_pkg::MEM_DEPTH];
    logic [AW-1:0] clr_reg, clr_next;
    logic [63:0]  buf_reg, buf_next;
    logic [6:0]   addr_reg, addr_next;
    logic [7:0]   idle_reg, idle_next;
    logic         done_reg, done_next;
    logic [2:0]   cnt_reg, cnt_next;
    logic [2:0]   nops_reg, nops_next;
    logic         rd_reg, rd_next;
    logic         rdpend_reg;
    logic [2:0]   rdslot_reg;
    logic [7:0]   rdata_reg;
    ucrh_pkg::result_t res_reg, res_next;

    logic         mem_we;
    logic [AW-1:0] mem_wa;
    logic [7:0]   mem_wd;
    logic         mem_re;
    logic [AW-1:0] mem_ra;
    logic [AW-1:0] base;
    logic [63:0]  newbuf;
    logic [7:0]   cmd;
    logic [3:0]   nlen;

    assign job_ready = (state_reg == ucrh_pkg::ST_IDLE);
    assign res_valid = (state_reg == ucrh_pkg::ST_OUT);
    assign res       = res_reg;
    assign cmd       = buf_reg[7:0];
    assign base      = AW'({buf_reg[15:8], buf_reg[23:16]});
    assign nlen      = (job.len_in > 8'd8) ? 4'd8 : job.len_in[3:0];

    always_comb
    begin
        newbuf = buf_reg;
        for (int i = 0; i < 8; i++)
            if (4'(i) < nlen)
                newbuf[8*i +: 8] = job.payload[8*i +: 8];
    end

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        buf_next   = buf_reg;
        addr_next  = addr_reg;
        idle_next  = idle_reg;
        done_next  = done_reg;
        cnt_next   = cnt_reg;
        nops_next  = nops_reg;
        rd_next    = rd_reg;
        res_next   = res_reg;
        mem_we     = 1'b0;
        mem_wa     = base + AW'(cnt_reg);
        mem_wd     = buf_reg[8*(3 + 32'(cnt_reg)) +: 8];
        mem_re     = 1'b0;
        mem_ra     = base + AW'(cnt_reg);
        if (rdpend_reg)
            buf_next[8*(3 + 32'(rdslot_reg)) +: 8] = rdata_reg;
        case (state_reg)
            ucrh_pkg::ST_CLEAR:
            begin
                mem_we = 1'b1;
                mem_wa = clr_reg;
                mem_wd = 8'd0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(ucrh_pkg::MEM_DEPTH - 1))
                    state_next = ucrh_pkg::ST_IDLE;
            end
            ucrh_pkg::ST_IDLE:
            begin
                if (job_valid)
                begin
                    res_next.hs   = job.hs;
                    res_next.src  = job.src;
                    res_next.off  = job.off;
                    res_next.len  = job.len;
                    res_next.inl  = job.inl;
                    state_next    = ucrh_pkg::ST_OUT;
                    case (job.op)
                        ucrh_pkg::OP_SET_ADDR:
                            if (!job.vlo[7])
                                addr_next = job.vlo[6:0];
                        ucrh_pkg::OP_GET_REPORT: res_next.inl = buf_reg;
                        ucrh_pkg::OP_GET_IDLE:   res_next.inl = {56'd0, idle_reg};
                        ucrh_pkg::OP_SET_IDLE:   idle_next = job.vhi;
                        ucrh_pkg::OP_REPORT_CMD:
                        begin
                            buf_next   = newbuf;
                            cnt_next   = 3'd0;
                            state_next = ucrh_pkg::ST_MEM;
                        end
                        default: ;
                    endcase
                end
            end
            ucrh_pkg::ST_MEM:
            begin
                // ST_MEM sees the updated buffer; decide the command
                if (cmd[7:4] == ucrh_pkg::CMD_BURST_HI[7:4])
                begin
                    nops_next = (cmd[3:0] > 4'd5) ? 3'd5 : cmd[2:0];
                    rd_next   = 1'b0;
                    state_next = ucrh_pkg::ST_WAIT;
                end
                else if (cmd == ucrh_pkg::CMD_READ)
                begin
                    nops_next = 3'd5;
                    rd_next   = 1'b1;
                    state_next = ucrh_pkg::ST_WAIT;
                end
                else if (cmd == ucrh_pkg::CMD_WRITE1)
                begin
                    nops_next = 3'd1;
                    rd_next   = 1'b0;
                    state_next = ucrh_pkg::ST_WAIT;
                end
                else
                begin
                    if (cmd == ucrh_pkg::CMD_END)
                        done_next = 1'b1;
                    state_next = ucrh_pkg::ST_OUT;
                end
            end
            ucrh_pkg::ST_WAIT:
            begin
                // one byte access a cycle; reads land in rdata_reg, then go to the buffer
                if (cnt_reg < nops_reg)
                begin
                    mem_we   = !rd_reg;
                    mem_re   = rd_reg;
                    cnt_next = cnt_reg + 3'd1;
                end
                else if (!rdpend_reg)
                    state_next = ucrh_pkg::ST_OUT;
            end
            ucrh_pkg::ST_OUT:
            begin
                if (res_ready)
                    state_next = ucrh_pkg::ST_IDLE;
            end
            default: state_next = ucrh_pkg::ST_IDLE;
        endcase
        res_next.addr = addr_next;
        res_next.done = done_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ucrh_pkg::ST_CLEAR;
            clr_reg    <= '0;
            buf_reg    <= '0;
            addr_reg   <= '0;
            idle_reg   <= '0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
            nops_reg   <= '0;
            rd_reg     <= 1'b0;
            rdpend_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            buf_reg    <= buf_next;
            addr_reg   <= addr_next;
            idle_reg   <= idle_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
            nops_reg   <= nops_next;
            rd_reg     <= rd_next;
            rdpend_reg <= mem_re;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg    <= res_next;
        rdslot_reg <= cnt_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        if (mem_re)
            rdata_reg <= mem[mem_ra];
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.hs != ucrh_pkg::HS_DATA || res.src != ucrh_pkg::SRC_NONE
                       || res.len == 6'd0))
        else $error("data-in without source must have zero length");
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> res_valid && $stable(res_reg))
        else $error("result changed while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(done_reg) |-> done_reg)
        else $error("end flag cleared");
    assert property (@(posedge clk) disable iff (!rst_n)
        rdpend_reg |-> state_reg == ucrh_pkg::ST_WAIT)
        else $error("memory read outside command run");

endmodule

[hdl/usb_control_request_handler.sv]
// ----------------------------------------------------------------------------
// usb_control_request_handler
// Endpoint-zero setup request handler with HID report command channel.
// ----------------------------------------------------------------------------
// s_axis carries one setup word (request fields plus report write payload);
// m_axis returns one answer word per request. A front stage decodes the
// request into a one-entry job register; the back stage executes it against
// the device state and a byte memory, then holds the answer in an output
// register until taken.
// Most requests pass through the job register and the output register; report
// writes also run the byte memory, one access per cycle (up to five bytes),
// and a read waits for its registered data. One request is executed at a
// time; the front stage can accept the next word while an answer waits.
// After reset the byte memory is swept to zero, one byte per cycle
// (MEM_DEPTH = 4096 bytes); during the sweep at most one word is accepted
// and held in the job register.
// A stalled m_axis holds its word stable and in turn stalls s_axis once the
// job register is full.
// ----------------------------------------------------------------------------
module usb_control_request_handler
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // request_type_byte, request_code, value_low, value_high, length_low,
    // report_payload
    input  logic [103:0]  s_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // handshake, data_source, data_offset, data_length, inline_data,
    // current_address, programming_done, zero pad
    output logic [87:0]   m_axis_tdata
);

    ucrh_pkg::job_t    job;
    ucrh_pkg::result_t res;
    logic              job_valid;
    logic              job_ready;

    ucrh_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (s_axis_tdata),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job)
    );

    ucrh_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (res)
    );

    assign m_axis_tdata = {1'b0, res.done, res.addr, res.inl, res.len,
                           res.off, res.src, res.hs};

endmodule
